// File: rtl/rbq_pkg.sv
package rbq_pkg;

    // Default queue depth
    localparam int DEPTH_DEF = 16;

    // Operation codes carried in the op field
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_COMMIT = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;
    localparam logic [1:0] OP_FLUSH  = 2'd3;

    // Request word
    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        instr_pc;
        logic [3:0]         instr_kind;
        logic [4:0]         dest_index;
        logic signed [31:0] result_value;
        logic [31:0]        done_cycle;
        logic [31:0]        cycle_now;
    } req_t;

    // Response word
    typedef struct packed {
        logic               accepted;
        logic               head_match;
        logic               write_valid;
        logic [4:0]         write_index;
        logic signed [31:0] write_value;
        logic [4:0]         popped_count;
        logic [4:0]         occupancy;
    } rsp_t;

    // One queue entry
    typedef struct packed {
        logic [31:0]        pc;
        logic [3:0]         kind;
        logic [4:0]         dest;
        logic signed [31:0] value;
        logic [31:0]        done_cycle;
    } entry_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;
        logic push_wr;
        logic pop;
        logic pop_count;
        logic load_out;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       full;
        logic       head_done;
    } dp_status_t;

endpackage

// File: rtl/rbq_ctrl.sv
module rbq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  rbq_pkg::dp_status_t   status,
    output rbq_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    // Output register may be reloaded when empty or being drained
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Sequence one operation
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                unique case (status.op)
                    rbq_pkg::OP_PUSH:
                    begin
                        if (out_free)
                        begin
                            cmd.push_wr    = !status.full;
                            cmd.load_out   = 1'b1;
                            rsp_valid_next = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                    rbq_pkg::OP_COMMIT:
                    begin
                        if (out_free)
                        begin
                            cmd.pop        = !status.empty && status.head_done;
                            cmd.load_out   = 1'b1;
                            rsp_valid_next = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                    rbq_pkg::OP_CHECK:
                    begin
                        if (out_free)
                        begin
                            cmd.load_out   = 1'b1;
                            rsp_valid_next = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                    rbq_pkg::OP_FLUSH:
                    begin
                        // drop completed heads one per cycle, then report
                        if (!status.empty && status.head_done)
                        begin
                            cmd.pop       = 1'b1;
                            cmd.pop_count = 1'b1;
                        end
                        else if (out_free)
                        begin
                            cmd.load_out   = 1'b1;
                            rsp_valid_next = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// File: rtl/rbq_datapath.sv
module rbq_datapath #(
    parameter int DEPTH = rbq_pkg::DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rbq_pkg::req_t        req,
    input  rbq_pkg::ctrl_cmd_t   cmd,
    output rbq_pkg::dp_status_t  status,
    output rbq_pkg::rsp_t        rsp
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    rbq_pkg::entry_t  mem [DEPTH];
    rbq_pkg::entry_t  head_rd_reg;
    rbq_pkg::entry_t  wr_entry;
    rbq_pkg::req_t    req_reg;
    rbq_pkg::rsp_t    rsp_reg;
    rbq_pkg::rsp_t    rsp_next;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] popped_reg;
    logic [CNT_W-1:0] popped_next;
    logic [CNT_W+4:0] occ_wide;
    logic [CNT_W+4:0] popped_wide;
    logic             empty;
    logic             full;
    logic             head_done;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
        if (ptr == LAST_SLOT)
            return '0;
        else
            return ptr + 1'b1;
    endfunction

    // Queue status
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == FULL_CNT);
    assign head_done = (head_rd_reg.done_cycle <= req_reg.cycle_now);

    assign status.op        = req_reg.op;
    assign status.empty     = empty;
    assign status.full      = full;
    assign status.head_done = head_done;

    // Advance pointers and counts
    assign head_next = cmd.pop ? next_slot(head_reg) : head_reg;
    assign tail_next = cmd.push_wr ? next_slot(tail_reg) : tail_reg;

    always_comb
    begin
        priority if (cmd.push_wr)
            count_next = count_reg + 1'b1;
        else if (cmd.pop)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    always_comb
    begin
        priority if (cmd.latch)
            popped_next = '0;
        else if (cmd.pop_count)
            popped_next = popped_reg + 1'b1;
        else
            popped_next = popped_reg;
    end

    // Counts are reported in five bits
    assign occ_wide    = (CNT_W + 5)'(count_next);
    assign popped_wide = (CNT_W + 5)'(popped_reg);

    // Form the response word
    always_comb
    begin
        rsp_next           = '0;
        rsp_next.occupancy = occ_wide[4:0];
        unique case (req_reg.op)
            rbq_pkg::OP_PUSH:
            begin
                rsp_next.accepted = !full;
            end
            rbq_pkg::OP_COMMIT:
            begin
                if (!empty && head_done)
                begin
                    rsp_next.write_valid = 1'b1;
                    rsp_next.write_index = head_rd_reg.dest;
                    rsp_next.write_value = head_rd_reg.value;
                end
            end
            rbq_pkg::OP_CHECK:
            begin
                rsp_next.head_match = !empty && (head_rd_reg.pc == req_reg.instr_pc)
                                      && (head_rd_reg.kind == req_reg.instr_kind);
            end
            rbq_pkg::OP_FLUSH:
            begin
                rsp_next.popped_count = popped_wide[4:0];
            end
        endcase
    end

    assign wr_entry.pc         = req_reg.instr_pc;
    assign wr_entry.kind       = req_reg.instr_kind;
    assign wr_entry.dest       = req_reg.dest_index;
    assign wr_entry.value      = req_reg.result_value;
    assign wr_entry.done_cycle = req_reg.done_cycle;

    // Entry store: write at tail, registered read of the coming head
    always_ff @(posedge clk)
    begin
        if (cmd.push_wr)
            mem[tail_reg] <= wr_entry;
        head_rd_reg <= mem[head_next];
    end

    // Hold request and response words
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            req_reg <= req;
        if (cmd.load_out)
            rsp_reg <= rsp_next;
    end

    // Pointers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            popped_reg <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            popped_reg <= popped_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// File: rtl/reorder_buffer_queue_unit.sv
// In-order reorder buffer queue of DEPTH entries. Each request word carries one
// operation: push appends an entry when there is room, commit retires the head
// once its completion cycle is at or before cycle_now and returns its register
// write, check compares the head's pc and kind, and flush drops completed heads
// and reports how many went. Every request yields exactly one response word,
// which also gives the occupancy after the operation. A request is latched in the
// idle state and evaluated in the evaluate state, so a new request is taken only
// once the last one has loaded its response. Flush drops completed entries one per
// cycle, as each step waits on the registered read of the new head entry from the
// entry store. The next request is taken while a response still waits in the
// output register, but its response is held back until that waiting word has
// been accepted.
module reorder_buffer_queue_unit #(
    parameter int DEPTH = rbq_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rbq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rbq_pkg::rsp_t rsp
);

    rbq_pkg::ctrl_cmd_t  cmd;
    rbq_pkg::dp_status_t status;

    rbq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rbq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

`ifndef SYNTHESIS
    // One request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in progress");

    // Never write into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_wr |-> !status.full)
        else $error("push written into full queue");

    // Never drop from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !status.empty)
        else $error("pop from empty queue");

    // An accepted push reports nothing of the other operations
    a_push_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.accepted) |->
            (!rsp.head_match && !rsp.write_valid && rsp.popped_count == 5'd0))
        else $error("push response carries fields of another operation");
`endif

endmodule
